>>> src/efdc_pkg.sv
// ----------------------------------------------------------------------------
// Elevator floor dispatch package
// Types, register indexes, reset values and field widths shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package efdc_pkg;

  localparam int unsigned FloorW   = 3;
  localparam int unsigned LightW   = 7;
  localparam int unsigned MaskW    = 5;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned DoorTW   = 16;
  localparam int unsigned TravelW  = 20;
  localparam int unsigned DurW     = 19;
  localparam int unsigned ChimeTW  = 10;
  localparam int unsigned BlinkW   = 10;
  localparam int unsigned StableW  = 8;
  localparam int unsigned ThrW     = 7;

  localparam logic [15:0] DoorHoldRst   = 16'd8000;
  localparam logic [15:0] DoorOpenRst   = 16'd3000;
  localparam logic [15:0] DoorCloseRst  = 16'd3000;
  localparam logic [15:0] FloorTravelRst = 16'd2000;
  localparam logic [7:0]  DebounceRst   = 8'd50;
  localparam logic [6:0]  ObstacleRst   = 7'd5;
  localparam logic [9:0]  BlinkRst      = 10'd200;
  localparam logic [9:0]  ChimeGapRst   = 10'd200;

  localparam logic [FloorW-1:0] GroundFloor = 3'd1;

  typedef enum logic [CfgAddrW-1:0] {
    REG_DOOR_HOLD,
    REG_DOOR_OPEN,
    REG_DOOR_CLOSE,
    REG_FLOOR_TRAVEL,
    REG_DEBOUNCE,
    REG_OBSTACLE_THR,
    REG_BLINK,
    REG_CHIME_GAP
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DP_WAIT,
    DP_MOVE,
    DP_OPEN,
    DP_CLOSE
  } disp_phase_e;

  typedef enum logic [1:0] {
    DM_OPENING,
    DM_OPENED,
    DM_CLOSING,
    DM_CLOSED
  } door_mode_e;

  typedef enum logic [1:0] {
    NOTE_NONE,
    NOTE_A4,
    NOTE_C4
  } chime_note_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_CAR
  } ctrl_state_e;

  typedef struct packed {
    logic [15:0] door_hold;
    logic [15:0] door_open;
    logic [15:0] door_close;
    logic [15:0] floor_travel;
    logic [7:0]  debounce;
    logic [6:0]  obstacle_thr;
    logic [9:0]  blink;
    logic [9:0]  chime_gap;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> src/efdc_in_if.sv
// ----------------------------------------------------------------------------
// Tick input channel
// One beat per millisecond tick: button level, selected floor, light level.
// ----------------------------------------------------------------------------
`default_nettype none

interface efdc_in_if;
  logic                            valid;
  logic                            ready;
  logic                            button_level;
  logic [efdc_pkg::FloorW-1:0]     selected_floor;
  logic [efdc_pkg::LightW-1:0]     light_percent;

  modport source (output valid, output button_level, output selected_floor,
                  output light_percent, input ready);
  modport sink (input valid, input button_level, input selected_floor,
                input light_percent, output ready);
endinterface

`default_nettype wire

>>> src/efdc_out_if.sv
// ----------------------------------------------------------------------------
// Status output channel
// One beat per tick: car, door, chime and queue status.
// ----------------------------------------------------------------------------
`default_nettype none

interface efdc_out_if;
  logic                            valid;
  logic                            ready;
  logic [efdc_pkg::FloorW-1:0]     current_floor;
  logic [efdc_pkg::FloorW-1:0]     target_floor;
  logic                            going_up;
  logic                            car_moving;
  logic [1:0]                      door_phase;
  logic                            door_lamp;
  logic [1:0]                      chime_note;
  logic [efdc_pkg::MaskW-1:0]      pending_mask;

  modport source (output valid, output current_floor, output target_floor,
                  output going_up, output car_moving, output door_phase,
                  output door_lamp, output chime_note, output pending_mask,
                  input ready);
  modport sink (input valid, input current_floor, input target_floor,
                input going_up, input car_moving, input door_phase,
                input door_lamp, input chime_note, input pending_mask,
                output ready);
endinterface

`default_nettype wire

>>> src/efdc_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data, one register per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface efdc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [efdc_pkg::CfgAddrW-1:0]   index;
  logic [efdc_pkg::CfgDataW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/elevator_floor_dispatch_controller.sv
// ----------------------------------------------------------------------------
// Elevator floor dispatch controller
// Per millisecond tick: debounce the call button, queue the selected floor,
// then step dispatcher, door, car and chime; one status beat per tick.
// ----------------------------------------------------------------------------
//  Channel | Dir | Beat contents
//  cfg_i   | in  | register index, write data
//  in_i    | in  | button_level, selected_floor, light_percent
//  out_o   | out | floors, direction, car, door, lamp, chime note, queue mask
//
//  Each tick steps in order through accept, one cycle per request slot
//  of the queue scan, request entry with dispatcher and door, car and chime.
//  The next tick can be accepted in the cycle after the previous one finishes.
//  One result register holds a beat; while it stalls, the car step waits.
//  rst_ni asynchronously resets control state and loads the default registers.
// ----------------------------------------------------------------------------
`default_nettype none

module elevator_floor_dispatch_controller #(
  parameter int unsigned NUM_FLOORS = 5
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  efdc_cfg_if.sink    cfg_i,
  efdc_in_if.sink     in_i,
  efdc_out_if.source  out_o
);

  localparam int unsigned IdxW = $clog2(NUM_FLOORS);

  efdc_pkg::cfg_t    cfg;
  efdc_pkg::cmd_t    cmd;
  efdc_pkg::status_t status;
  logic [IdxW-1:0]   idx;
  logic              in_ready;
  logic              cfg_ready;
  logic              out_valid;
  logic [efdc_pkg::FloorW-1:0] cur_floor;
  logic [efdc_pkg::FloorW-1:0] tgt_floor;
  logic              going_up;
  logic              car_moving;
  logic [1:0]        door_phase;
  logic              door_lamp;
  logic [1:0]        chime_note;
  logic [efdc_pkg::MaskW-1:0] pending_mask;

  assign cfg_i.ready = cfg_ready;
  assign in_i.ready  = in_ready;

  assign out_o.valid         = out_valid;
  assign out_o.current_floor = cur_floor;
  assign out_o.target_floor  = tgt_floor;
  assign out_o.going_up      = going_up;
  assign out_o.car_moving    = car_moving;
  assign out_o.door_phase    = door_phase;
  assign out_o.door_lamp     = door_lamp;
  assign out_o.chime_note    = chime_note;
  assign out_o.pending_mask  = pending_mask;

  efdc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cfg_i.valid),
    .index_i (cfg_i.index),
    .data_i  (cfg_i.data),
    .ready_o (cfg_ready),
    .cfg_o   (cfg)
  );

  efdc_ctrl #(
    .NUM_FLOORS (NUM_FLOORS),
    .IdxW       (IdxW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  efdc_datapath #(
    .NUM_FLOORS (NUM_FLOORS),
    .IdxW       (IdxW)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .idx_i            (idx),
    .status_o         (status),
    .button_level_i   (in_i.button_level),
    .selected_floor_i (in_i.selected_floor),
    .light_percent_i  (in_i.light_percent),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_o.ready),
    .current_floor_o  (cur_floor),
    .target_floor_o   (tgt_floor),
    .going_up_o       (going_up),
    .car_moving_o     (car_moving),
    .door_phase_o     (door_phase),
    .door_lamp_o      (door_lamp),
    .chime_note_o     (chime_note),
    .pending_mask_o   (pending_mask)
  );

endmodule

`default_nettype wire

>>> src/efdc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Timing and threshold registers, written one per beat, reset to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module efdc_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire logic [efdc_pkg::CfgAddrW-1:0] index_i,
  input  wire logic [efdc_pkg::CfgDataW-1:0] data_i,
  output logic                               ready_o,
  output efdc_pkg::cfg_t                     cfg_o
);

  efdc_pkg::cfg_t cfg_q;
  efdc_pkg::cfg_t cfg_d;

  assign ready_o = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (valid_i) begin
      case (efdc_pkg::cfg_reg_e'(index_i))
        efdc_pkg::REG_DOOR_HOLD:    cfg_d.door_hold    = data_i;
        efdc_pkg::REG_DOOR_OPEN:    cfg_d.door_open    = data_i;
        efdc_pkg::REG_DOOR_CLOSE:   cfg_d.door_close   = data_i;
        efdc_pkg::REG_FLOOR_TRAVEL: cfg_d.floor_travel = data_i;
        efdc_pkg::REG_DEBOUNCE:     cfg_d.debounce     = data_i[7:0];
        efdc_pkg::REG_OBSTACLE_THR: cfg_d.obstacle_thr = data_i[6:0];
        efdc_pkg::REG_BLINK:        cfg_d.blink        = data_i[9:0];
        efdc_pkg::REG_CHIME_GAP:    cfg_d.chime_gap    = data_i[9:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.door_hold    <= efdc_pkg::DoorHoldRst;
      cfg_q.door_open    <= efdc_pkg::DoorOpenRst;
      cfg_q.door_close   <= efdc_pkg::DoorCloseRst;
      cfg_q.floor_travel <= efdc_pkg::FloorTravelRst;
      cfg_q.debounce     <= efdc_pkg::DebounceRst;
      cfg_q.obstacle_thr <= efdc_pkg::ObstacleRst;
      cfg_q.blink        <= efdc_pkg::BlinkRst;
      cfg_q.chime_gap    <= efdc_pkg::ChimeGapRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

>>> src/efdc_ctrl.sv
// ----------------------------------------------------------------------------
// Tick sequencer
// Accepts a tick, walks the request slots, then issues the apply and
// finish steps to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module efdc_ctrl #(
  parameter int unsigned NUM_FLOORS = 5,
  parameter int unsigned IdxW       = $clog2(NUM_FLOORS)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire efdc_pkg::status_t status_i,
  output efdc_pkg::cmd_t         cmd_o,
  output logic [IdxW-1:0]        idx_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_FLOORS - 1);

  efdc_pkg::ctrl_state_e state_q, state_d;
  logic [IdxW-1:0]       idx_q, idx_d;

  assign idx_o = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= efdc_pkg::ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      efdc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          state_d    = efdc_pkg::ST_SCAN;
        end
      end
      efdc_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (idx_q == LastIdx) begin
          state_d = efdc_pkg::ST_APPLY;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      efdc_pkg::ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = efdc_pkg::ST_CAR;
      end
      efdc_pkg::ST_CAR: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = efdc_pkg::ST_IDLE;
        end
      end
      default: state_d = efdc_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> src/efdc_datapath.sv
// ----------------------------------------------------------------------------
// Dispatch datapath
// Debounce, request slots, dispatcher, door, car, chime and the result
// register, stepped by commands from the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module efdc_datapath #(
  parameter int unsigned NUM_FLOORS = 5,
  parameter int unsigned IdxW       = $clog2(NUM_FLOORS)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire efdc_pkg::cfg_t                 cfg_i,
  input  wire efdc_pkg::cmd_t                 cmd_i,
  input  wire logic [IdxW-1:0]                idx_i,
  output efdc_pkg::status_t                   status_o,
  input  wire logic                           button_level_i,
  input  wire logic [efdc_pkg::FloorW-1:0]    selected_floor_i,
  input  wire logic [efdc_pkg::LightW-1:0]    light_percent_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [efdc_pkg::FloorW-1:0]         current_floor_o,
  output logic [efdc_pkg::FloorW-1:0]         target_floor_o,
  output logic                                going_up_o,
  output logic                                car_moving_o,
  output logic [1:0]                          door_phase_o,
  output logic                                door_lamp_o,
  output logic [1:0]                          chime_note_o,
  output logic [efdc_pkg::MaskW-1:0]          pending_mask_o
);

  localparam int unsigned FW = efdc_pkg::FloorW;

  // queue
  logic [NUM_FLOORS-1:0] slot_v_q, slot_v_d;
  logic [FW-1:0]         slot_f_q [NUM_FLOORS];
  logic [FW-1:0]         slot_f_d [NUM_FLOORS];

  // tick inputs
  logic [FW-1:0]                 sel_q, sel_d;
  logic [efdc_pkg::LightW-1:0]   light_q, light_d;
  logic                          pressed_q, pressed_d;

  // scan results
  logic            dup_q, dup_d;
  logic            emp_found_q, emp_found_d;
  logic [IdxW-1:0] emp_idx_q, emp_idx_d;
  logic            cand_found_q, cand_found_d;
  logic [IdxW-1:0] cand_idx_q, cand_idx_d;
  logic [FW-1:0]   cand_f_q, cand_f_d;
  logic            rm_found_q, rm_found_d;
  logic [IdxW-1:0] rm_idx_q, rm_idx_d;

  // controller state
  logic [FW-1:0]                floor_now_q, floor_now_d;
  logic [FW-1:0]                floor_goal_q, floor_goal_d;
  logic                         dir_up_q, dir_up_d;
  efdc_pkg::disp_phase_e        disp_q, disp_d;
  efdc_pkg::door_mode_e         door_q, door_d;
  logic                         car_q, car_d;
  logic                         shut_q, shut_d;
  logic                         open_cmd_q, open_cmd_d;
  logic                         ring_q, ring_d;
  logic                         chime_act_q, chime_act_d;
  logic [efdc_pkg::HoldW-1:0]   hold_q, hold_d;
  logic [efdc_pkg::DoorTW-1:0]  door_t_q, door_t_d;
  logic [efdc_pkg::TravelW-1:0] travel_q, travel_d;
  logic [efdc_pkg::ChimeTW-1:0] chime_t_q, chime_t_d;
  logic [efdc_pkg::BlinkW-1:0]  blink_q, blink_d;
  logic                         lamp_q, lamp_d;
  logic [efdc_pkg::StableW-1:0] stable_q, stable_d;
  logic                         prev_q, prev_d;
  logic                         bstable_q, bstable_d;

  // result register
  logic                         out_valid_q, out_valid_d;
  logic [FW-1:0]                o_cur_q, o_cur_d;
  logic [FW-1:0]                o_tgt_q, o_tgt_d;
  logic                         o_up_q, o_up_d;
  logic                         o_car_q, o_car_d;
  logic [1:0]                   o_door_q, o_door_d;
  logic                         o_lamp_q, o_lamp_d;
  efdc_pkg::chime_note_e        o_note_q, o_note_d;
  logic [efdc_pkg::MaskW-1:0]   o_mask_q, o_mask_d;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign current_floor_o = o_cur_q;
  assign target_floor_o  = o_tgt_q;
  assign going_up_o      = o_up_q;
  assign car_moving_o    = o_car_q;
  assign door_phase_o    = o_door_q;
  assign door_lamp_o     = o_lamp_q;
  assign chime_note_o    = o_note_q;
  assign pending_mask_o  = o_mask_q;

  always_comb begin
    logic                       sv;
    logic [FW-1:0]              sf;
    logic                       beyond;
    logic                       add;
    logic                       sel_beyond;
    logic                       use_sel;
    logic                       nxt_found;
    logic [FW-1:0]              nxt_f;
    logic [FW-1:0]              span;
    logic [efdc_pkg::DurW-1:0]  dur;
    logic [efdc_pkg::MaskW-1:0] mask;

    slot_v_d     = slot_v_q;
    slot_f_d     = slot_f_q;
    sel_d        = sel_q;
    light_d      = light_q;
    pressed_d    = pressed_q;
    dup_d        = dup_q;
    emp_found_d  = emp_found_q;
    emp_idx_d    = emp_idx_q;
    cand_found_d = cand_found_q;
    cand_idx_d   = cand_idx_q;
    cand_f_d     = cand_f_q;
    rm_found_d   = rm_found_q;
    rm_idx_d     = rm_idx_q;
    floor_now_d  = floor_now_q;
    floor_goal_d = floor_goal_q;
    dir_up_d     = dir_up_q;
    disp_d       = disp_q;
    door_d       = door_q;
    car_d        = car_q;
    shut_d       = shut_q;
    open_cmd_d   = open_cmd_q;
    ring_d       = ring_q;
    chime_act_d  = chime_act_q;
    hold_d       = hold_q;
    door_t_d     = door_t_q;
    travel_d     = travel_q;
    chime_t_d    = chime_t_q;
    blink_d      = blink_q;
    lamp_d       = lamp_q;
    stable_d     = stable_q;
    prev_d       = prev_q;
    bstable_d    = bstable_q;
    out_valid_d  = out_valid_q;
    o_cur_d      = o_cur_q;
    o_tgt_d      = o_tgt_q;
    o_up_d       = o_up_q;
    o_car_d      = o_car_q;
    o_door_d     = o_door_q;
    o_lamp_d     = o_lamp_q;
    o_note_d     = o_note_q;
    o_mask_d     = o_mask_q;

    sv         = slot_v_q[idx_i];
    sf         = slot_f_q[idx_i];
    beyond     = dir_up_q ? (sf > floor_now_q) : (sf < floor_now_q);
    add        = pressed_q && (sel_q != '0) && (32'(sel_q) <= 32'(NUM_FLOORS)) &&
                 (sel_q != floor_now_q) && !dup_q && emp_found_q;
    sel_beyond = dir_up_q ? (sel_q > floor_now_q) : (sel_q < floor_now_q);
    use_sel    = add && sel_beyond && (!cand_found_q || (emp_idx_q < cand_idx_q));
    nxt_found  = use_sel || cand_found_q;
    nxt_f      = use_sel ? sel_q : cand_f_q;
    span       = '0;
    dur        = '0;
    mask       = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // debounce and latch the tick
    if (cmd_i.load) begin
      if (blink_q != '1) begin
        blink_d = blink_q + 1'b1;
      end
      if (button_level_i != prev_q) begin
        stable_d = '0;
      end else if (stable_q != '1) begin
        stable_d = stable_q + 1'b1;
      end
      pressed_d = 1'b0;
      if ((stable_d > cfg_i.debounce) && (button_level_i != bstable_q)) begin
        bstable_d = button_level_i;
        pressed_d = button_level_i;
      end
      prev_d       = button_level_i;
      sel_d        = selected_floor_i;
      light_d      = light_percent_i;
      dup_d        = 1'b0;
      emp_found_d  = 1'b0;
      cand_found_d = 1'b0;
      rm_found_d   = 1'b0;
    end

    // one slot per cycle
    if (cmd_i.scan) begin
      if (sv && (sf == sel_q)) begin
        dup_d = 1'b1;
      end
      if (!sv && !emp_found_q) begin
        emp_found_d = 1'b1;
        emp_idx_d   = idx_i;
      end
      if (sv && beyond && !cand_found_q) begin
        cand_found_d = 1'b1;
        cand_idx_d   = idx_i;
        cand_f_d     = sf;
      end
      if (sv && (sf == floor_now_q) && !rm_found_q) begin
        rm_found_d = 1'b1;
        rm_idx_d   = idx_i;
      end
    end

    // request entry, dispatcher, door
    if (cmd_i.apply) begin
      if (add) begin
        slot_v_d[emp_idx_q] = 1'b1;
        slot_f_d[emp_idx_q] = sel_q;
      end

      case (disp_q)
        efdc_pkg::DP_WAIT: begin
          if (!nxt_found) begin
            dir_up_d = !dir_up_q;
          end else if (shut_q) begin
            floor_goal_d = nxt_f;
            disp_d       = efdc_pkg::DP_MOVE;
          end
        end
        efdc_pkg::DP_MOVE: begin
          if (floor_now_q == floor_goal_q) begin
            shut_d     = 1'b0;
            disp_d     = efdc_pkg::DP_OPEN;
            open_cmd_d = 1'b1;
            ring_d     = 1'b1;
            hold_d     = '0;
          end
        end
        efdc_pkg::DP_OPEN: begin
          if (hold_q != '1) begin
            hold_d = hold_q + 1'b1;
          end
          if (hold_d >= cfg_i.door_hold) begin
            open_cmd_d = 1'b0;
            if (rm_found_q) begin
              slot_v_d[rm_idx_q] = 1'b0;
            end
            floor_now_d = floor_goal_q;
            disp_d      = efdc_pkg::DP_CLOSE;
          end
        end
        default: disp_d = efdc_pkg::DP_WAIT;
      endcase

      case (door_q)
        efdc_pkg::DM_OPENING: begin
          if (door_t_q != '1) begin
            door_t_d = door_t_q + 1'b1;
          end
          if (blink_d >= cfg_i.blink) begin
            blink_d = '0;
            lamp_d  = !lamp_d;
          end
          if (door_t_d >= cfg_i.door_open) begin
            if (blink_d >= cfg_i.blink) begin
              blink_d = '0;
              lamp_d  = !lamp_d;
            end
            door_d = efdc_pkg::DM_OPENED;
          end
        end
        efdc_pkg::DM_OPENED: begin
          lamp_d = 1'b1;
          if (!open_cmd_d) begin
            door_d   = efdc_pkg::DM_CLOSING;
            door_t_d = '0;
          end
        end
        efdc_pkg::DM_CLOSING: begin
          shut_d = 1'b0;
          if (door_t_q != '1) begin
            door_t_d = door_t_q + 1'b1;
          end
          if (blink_d >= cfg_i.blink) begin
            blink_d = '0;
            lamp_d  = !lamp_d;
          end
          if (light_q < cfg_i.obstacle_thr) begin
            door_t_d = '0;
          end else if (door_t_d >= cfg_i.door_close) begin
            door_d = efdc_pkg::DM_CLOSED;
          end
        end
        default: begin
          shut_d = 1'b1;
          lamp_d = 1'b0;
          if (open_cmd_d) begin
            door_d   = efdc_pkg::DM_OPENING;
            door_t_d = '0;
          end
        end
      endcase
    end

    // car, chime and result
    if (cmd_i.finish) begin
      span = (floor_goal_q >= floor_now_q) ? (floor_goal_q - floor_now_q)
                                           : (floor_now_q - floor_goal_q);
      dur  = efdc_pkg::DurW'(span) * efdc_pkg::DurW'(cfg_i.floor_travel);
      if (!car_q) begin
        if ((span != '0) && shut_q) begin
          travel_d = '0;
          car_d    = 1'b1;
        end
      end else begin
        if (travel_q != '1) begin
          travel_d = travel_q + 1'b1;
        end
        if (travel_d >= {1'b0, dur}) begin
          floor_now_d = floor_goal_q;
          car_d       = 1'b0;
        end
      end

      o_note_d = efdc_pkg::NOTE_NONE;
      if (!chime_act_q) begin
        if (ring_q) begin
          chime_act_d = 1'b1;
          chime_t_d   = '0;
        end
      end else begin
        if (chime_t_q != '1) begin
          chime_t_d = chime_t_q + 1'b1;
        end
        if (dir_up_q) begin
          o_note_d    = efdc_pkg::NOTE_A4;
          chime_act_d = 1'b0;
          ring_d      = 1'b0;
        end else begin
          o_note_d = efdc_pkg::NOTE_C4;
          if (chime_t_d >= cfg_i.chime_gap) begin
            o_note_d    = efdc_pkg::NOTE_A4;
            chime_act_d = 1'b0;
            ring_d      = 1'b0;
          end
        end
      end

      for (int k = 0; k < efdc_pkg::MaskW; k++) begin
        for (int i = 0; i < NUM_FLOORS; i++) begin
          if (slot_v_q[i] && (slot_f_q[i] == FW'(k + 1))) begin
            mask[k] = 1'b1;
          end
        end
      end

      out_valid_d = 1'b1;
      o_cur_d     = floor_now_d;
      o_tgt_d     = floor_goal_q;
      o_up_d      = dir_up_q;
      o_car_d     = car_d;
      o_door_d    = door_q;
      o_lamp_d    = lamp_q;
      o_mask_d    = mask;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_f_q <= slot_f_d;
    sel_q    <= sel_d;
    light_q  <= light_d;
    cand_f_q <= cand_f_d;
    emp_idx_q  <= emp_idx_d;
    cand_idx_q <= cand_idx_d;
    rm_idx_q   <= rm_idx_d;
    o_cur_q  <= o_cur_d;
    o_tgt_q  <= o_tgt_d;
    o_up_q   <= o_up_d;
    o_car_q  <= o_car_d;
    o_door_q <= o_door_d;
    o_lamp_q <= o_lamp_d;
    o_note_q <= o_note_d;
    o_mask_q <= o_mask_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_v_q     <= '0;
      pressed_q    <= 1'b0;
      dup_q        <= 1'b0;
      emp_found_q  <= 1'b0;
      cand_found_q <= 1'b0;
      rm_found_q   <= 1'b0;
      floor_now_q  <= efdc_pkg::GroundFloor;
      floor_goal_q <= efdc_pkg::GroundFloor;
      dir_up_q     <= 1'b0;
      disp_q       <= efdc_pkg::DP_WAIT;
      door_q       <= efdc_pkg::DM_CLOSED;
      car_q        <= 1'b0;
      shut_q       <= 1'b1;
      open_cmd_q   <= 1'b0;
      ring_q       <= 1'b0;
      chime_act_q  <= 1'b0;
      hold_q       <= '0;
      door_t_q     <= '0;
      travel_q     <= '0;
      chime_t_q    <= '0;
      blink_q      <= '0;
      lamp_q       <= 1'b0;
      stable_q     <= '0;
      prev_q       <= 1'b0;
      bstable_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      slot_v_q     <= slot_v_d;
      pressed_q    <= pressed_d;
      dup_q        <= dup_d;
      emp_found_q  <= emp_found_d;
      cand_found_q <= cand_found_d;
      rm_found_q   <= rm_found_d;
      floor_now_q  <= floor_now_d;
      floor_goal_q <= floor_goal_d;
      dir_up_q     <= dir_up_d;
      disp_q       <= disp_d;
      door_q       <= door_d;
      car_q        <= car_d;
      shut_q       <= shut_d;
      open_cmd_q   <= open_cmd_d;
      ring_q       <= ring_d;
      chime_act_q  <= chime_act_d;
      hold_q       <= hold_d;
      door_t_q     <= door_t_d;
      travel_q     <= travel_d;
      chime_t_q    <= chime_t_d;
      blink_q      <= blink_d;
      lamp_q       <= lamp_d;
      stable_q     <= stable_d;
      prev_q       <= prev_d;
      bstable_q    <= bstable_d;
      out_valid_q  <= out_valid_d;
    end
  end

endmodule

`default_nettype wire
